// ----- rtl/page_bitmap_range_marker_defines.svh -----
// Assertion macros used by the page bitmap range marker checker
`ifndef PAGE_BITMAP_RANGE_MARKER_DEFINES_SVH
`define PAGE_BITMAP_RANGE_MARKER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define PBRM_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PBRM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/pbrm_pkg.sv -----
// Shared widths, codes and types of the page bitmap range marker
package pbrm_pkg;

    localparam int ADDR_W     = 32;
    localparam int COUNT_W    = 29;
    localparam int END_W      = 33;
    localparam int CFG_W      = 29;
    localparam int STATUS_W   = 3;
    localparam int CONFLICT_W = 16;
    localparam int TOUCHED_W  = 17;
    localparam int CFG_IDX_W  = 1;

    typedef logic [STATUS_W-1:0]  t_status;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_status ST_OK           = 3'd0;
    localparam t_status ST_BELOW        = 3'd1;
    localparam t_status ST_ABOVE        = 3'd2;
    localparam t_status ST_DOUBLE_ALLOC = 3'd3;
    localparam t_status ST_DOUBLE_FREE  = 3'd4;

    localparam t_cfg_idx CFG_MEM_LOWEST  = 1'd0;
    localparam t_cfg_idx CFG_MEM_HIGHEST = 1'd1;

    localparam logic [CFG_W-1:0] MEM_LOWEST_RST  = 29'd0;
    localparam logic [CFG_W-1:0] MEM_HIGHEST_RST = 29'd268435456;

endpackage

// ----- rtl/pbrm_req_if.sv -----
// Request channel: operation and byte range of one word
interface pbrm_req_if;
    import pbrm_pkg::*;

    logic               valid;
    logic               ready;
    logic               operation;
    logic [ADDR_W-1:0]  start_address;
    logic [COUNT_W-1:0] byte_count;

    modport source (output valid, operation, start_address, byte_count, input ready);
    modport sink   (input valid, operation, start_address, byte_count, output ready);
endinterface

// ----- rtl/pbrm_rsp_if.sv -----
// Response channel: status, first conflicting page and page count of one word
interface pbrm_rsp_if;
    import pbrm_pkg::*;

    logic                  valid;
    logic                  ready;
    t_status               status;
    logic [CONFLICT_W-1:0] first_conflict_page;
    logic [TOUCHED_W-1:0]  pages_touched;

    modport source (output valid, status, first_conflict_page, pages_touched, input ready);
    modport sink   (input valid, status, first_conflict_page, pages_touched, output ready);
endinterface

// ----- rtl/pbrm_bitmap_ram.sv -----
// Bitmap word store: one write port, one read port with registered data
module pbrm_bitmap_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 32,
    parameter int AW    = 11
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/page_bitmap_range_marker.sv -----
// Each accepted word is range-checked, then the bitmap words its page range spans are updated,
// then its result is registered; a bounds error or an empty range skips the update.
// Memory words are read-modified-written one per cycle, and a new word is taken once the
// result is held in the output register.
// Reset: synchronous; a clearing pass then writes all ones over the bitmap, one memory word
// a cycle (2048 words at default sizes), during which no word is accepted.
module page_bitmap_range_marker #(
    parameter int PAGE_BYTES = 4096,
    parameter int MAX_PAGES  = 65536,
    parameter int WORD_BITS  = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    pbrm_req_if.sink                   i_req,
    pbrm_rsp_if.source                 o_rsp,
    input  logic                       i_cfg_we,
    input  pbrm_pkg::t_cfg_idx         i_cfg_idx,
    input  logic [pbrm_pkg::CFG_W-1:0] i_cfg_wdata
);
    import pbrm_pkg::*;

    localparam int PB_SH    = $clog2(PAGE_BYTES);
    localparam int WB_SH    = $clog2(WORD_BITS);
    localparam int PAGE_W   = END_W - PB_SH;
    localparam int BM_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W  = (BM_WORDS > 1) ? $clog2(BM_WORDS) : 1;
    localparam logic [WORD_BITS-1:0] ONES = '1;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_RUN   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]            r_state, n_state;
    logic [WADDR_W-1:0]    r_clr_addr;

    logic [CFG_W-1:0]      r_lowest, r_highest;

    logic                  r_free;
    logic [ADDR_W-1:0]     r_start;
    logic [END_W-1:0]      r_end;

    logic [WADDR_W-1:0]    r_first_word, r_last_word;
    logic [WB_SH-1:0]      r_lo_bit, r_hi_bit;
    logic [WADDR_W-1:0]    r_rd_addr, r_wr_addr;
    logic                  r_rd_more, r_rd_pend;

    t_status               r_status;
    logic                  r_found;
    logic [CONFLICT_W-1:0] r_conflict;
    logic [TOUCHED_W-1:0]  r_touched;

    logic                  r_out_valid;
    t_status               r_out_status;
    logic [CONFLICT_W-1:0] r_out_conflict;
    logic [TOUCHED_W-1:0]  r_out_touched;

    // range check and page arithmetic
    logic [PAGE_W-1:0]     first_page, end_page, last_page;
    logic                  below, above;

    // word update
    logic [WORD_BITS-1:0]  rd_data, mask, hits, new_word;
    logic [WORD_BITS-1:0]  lo_mask, hi_mask;
    logic [WB_SH-1:0]      hit_idx;

    logic                  ram_we, ram_re;
    logic [WADDR_W-1:0]    ram_waddr;
    logic [WORD_BITS-1:0]  ram_wdata;
    logic                  out_load, run_end;

    function automatic logic [WB_SH-1:0] f_first_set(input logic [WORD_BITS-1:0] v);
        logic [WB_SH-1:0] idx;
        idx = '0;
        for (int k = WORD_BITS - 1; k >= 0; k--) begin
            if (v[k]) begin
                idx = WB_SH'(k);
            end
        end
        return idx;
    endfunction

    assign first_page = PAGE_W'(r_start[ADDR_W-1:PB_SH]);
    assign end_page   = r_end[END_W-1:PB_SH];
    assign last_page  = end_page - PAGE_W'(1);
    assign below      = r_start < ADDR_W'(r_lowest);
    assign above      = (r_end > END_W'(r_highest)) ||
                        (END_W'(end_page) > END_W'(MAX_PAGES));

    assign lo_mask  = (r_wr_addr == r_first_word) ? (ONES << r_lo_bit) : ONES;
    assign hi_mask  = (r_wr_addr == r_last_word) ?
                      (ONES >> (WB_SH'(WORD_BITS - 1) - r_hi_bit)) : ONES;
    assign mask     = lo_mask & hi_mask;
    assign hits     = r_free ? (~rd_data & mask) : (rd_data & mask);
    assign new_word = r_free ? (rd_data & ~mask) : (rd_data | mask);
    assign hit_idx  = f_first_set(hits);

    assign run_end  = !r_rd_more && r_rd_pend;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == WADDR_W'(BM_WORDS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_req.valid) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (below || above || end_page == first_page) n_state = S_DONE;
                else n_state = S_RUN;
            end
            S_RUN: begin
                if (run_end) n_state = S_DONE;
            end
            S_DONE: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + WADDR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lowest  <= MEM_LOWEST_RST;
            r_highest <= MEM_HIGHEST_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MEM_LOWEST:  r_lowest  <= i_cfg_wdata;
                CFG_MEM_HIGHEST: r_highest <= i_cfg_wdata;
            endcase
        end
    end

    // capture the word; the end address is kept 33 bits wide so it never wraps
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req.valid) begin
            r_free  <= i_req.operation;
            r_start <= i_req.start_address;
            r_end   <= END_W'(i_req.start_address) + END_W'(i_req.byte_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_more <= 1'b0;
            r_rd_pend <= 1'b0;
            r_found   <= 1'b0;
        end else if (r_state == S_CHECK) begin
            r_rd_more <= !(below || above || end_page == first_page);
            r_rd_pend <= 1'b0;
            r_found   <= 1'b0;
        end else if (r_state == S_RUN) begin
            r_rd_pend <= r_rd_more;
            if (r_rd_more && r_rd_addr == r_last_word) begin
                r_rd_more <= 1'b0;
            end
            if (r_rd_pend && |hits) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CHECK) begin
            r_first_word <= WADDR_W'(first_page >> WB_SH);
            r_last_word  <= WADDR_W'(last_page >> WB_SH);
            r_rd_addr    <= WADDR_W'(first_page >> WB_SH);
            r_lo_bit     <= first_page[WB_SH-1:0];
            r_hi_bit     <= last_page[WB_SH-1:0];
            r_conflict   <= '0;
            if (below) begin
                r_status  <= ST_BELOW;
                r_touched <= '0;
            end else if (above) begin
                r_status  <= ST_ABOVE;
                r_touched <= '0;
            end else begin
                r_status  <= ST_OK;
                r_touched <= TOUCHED_W'(end_page - first_page);
            end
        end else if (r_state == S_RUN) begin
            if (r_rd_more) begin
                r_rd_addr <= r_rd_addr + WADDR_W'(1);
            end
            r_wr_addr <= r_rd_addr;
            // only the first page already in the target state is reported
            if (r_rd_pend && |hits && !r_found) begin
                r_conflict <= CONFLICT_W'({r_wr_addr, hit_idx});
                r_status   <= r_free ? ST_DOUBLE_FREE : ST_DOUBLE_ALLOC;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status   <= r_status;
            r_out_conflict <= r_conflict;
            r_out_touched  <= r_touched;
        end
    end

    // the clearing pass and the update step share the one write port
    assign ram_we    = (r_state == S_CLEAR) || (r_state == S_RUN && r_rd_pend);
    assign ram_waddr = (r_state == S_CLEAR) ? r_clr_addr : r_wr_addr;
    assign ram_wdata = (r_state == S_CLEAR) ? ONES : new_word;
    assign ram_re    = (r_state == S_RUN) && r_rd_more;

    pbrm_bitmap_ram #(
        .DEPTH (BM_WORDS),
        .WIDTH (WORD_BITS),
        .AW    (WADDR_W)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_rd_addr),
        .o_rdata (rd_data)
    );

    assign i_req.ready               = (r_state == S_IDLE);
    assign o_rsp.valid               = r_out_valid;
    assign o_rsp.status              = r_out_status;
    assign o_rsp.first_conflict_page = r_out_conflict;
    assign o_rsp.pages_touched       = r_out_touched;

endmodule

// ----- rtl/pbrm_checker.sv -----
// Port-level checker for the page bitmap range marker, bound to the top level
`include "page_bitmap_range_marker_defines.svh"

module pbrm_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_req_valid,
    input logic                            i_req_ready,
    input logic                            i_rsp_valid,
    input logic                            i_rsp_ready,
    input pbrm_pkg::t_status               i_status,
    input logic [pbrm_pkg::CONFLICT_W-1:0] i_conflict,
    input logic [pbrm_pkg::TOUCHED_W-1:0]  i_touched
);
    import pbrm_pkg::*;

    `PBRM_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_status) && $stable(i_conflict) && $stable(i_touched), "stalled response word changed")
    `PBRM_ASSERT_NEXT(a_one_word, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_req_ready, "request taken while a word is in progress")
    `PBRM_ASSERT_SAME(a_status_code, i_clk, i_rst_n, i_rsp_valid, i_status == ST_OK || i_status == ST_BELOW || i_status == ST_ABOVE || i_status == ST_DOUBLE_ALLOC || i_status == ST_DOUBLE_FREE, "undefined status code")
    `PBRM_ASSERT_SAME(a_no_conflict, i_clk, i_rst_n, i_rsp_valid && (i_status == ST_OK || i_status == ST_BELOW || i_status == ST_ABOVE), i_conflict == '0, "conflict page without a conflict")
    `PBRM_ASSERT_SAME(a_err_empty, i_clk, i_rst_n, i_rsp_valid && (i_status == ST_BELOW || i_status == ST_ABOVE), i_touched == '0, "pages counted on a bounds error")

endmodule

bind page_bitmap_range_marker pbrm_checker u_pbrm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_conflict  (o_rsp.first_conflict_page),
    .i_touched   (o_rsp.pages_touched)
);
